FILE: rtl/rvimm_pkg.sv
// Package with the opcode, funct3 and funct6 codes for the RV64I OP-IMM execute unit.
package rvimm_pkg;

	localparam int XLEN      = 64;
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = 5;
	localparam int SHAMT_W   = 6;

	localparam logic [6:0] OPC_OP_IMM = 7'h13;

	localparam logic [2:0] F3_ADDI  = 3'd0;
	localparam logic [2:0] F3_SLLI  = 3'd1;
	localparam logic [2:0] F3_SLTI  = 3'd2;
	localparam logic [2:0] F3_SLTIU = 3'd3;
	localparam logic [2:0] F3_XORI  = 3'd4;
	localparam logic [2:0] F3_SRXI  = 3'd5;
	localparam logic [2:0] F3_ORI   = 3'd6;
	localparam logic [2:0] F3_ANDI  = 3'd7;

	localparam logic [5:0] F6_SRLI = 6'h00;
	localparam logic [5:0] F6_SRAI = 6'h10;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_BADOPC = 1'b1;

	typedef logic [XLEN-1:0] xword_t;

endpackage

FILE: rtl/rv64_imm_alu_execute.sv
// Top level of the RV64I OP-IMM execute unit with its 32 x 64 register file.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | instr_word[31:0]
//  output  | out_valid / out_ready| status, wrote, dest_index[4:0], dest_value
//
// Each transaction sits in the instruction register (stage 1), where the
// register file is read and the ALU result is formed, until stage 2 is free,
// and then sits in the result register (stage 2) until it is taken.
// With out_ready held high a new transaction is accepted every cycle.
// The register file is written at the same edge that moves an instruction
// from stage 1 to stage 2, so the following instruction always reads the
// updated value and no forwarding path is needed.
// Reset clears the valid flags and all 32 registers at once.
// A stall on the output holds stage 2 and any instruction in stage 1, and drops in_ready while stage 1 is full.
module rv64_imm_alu_execute (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   instr_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic                          wrote,
	output logic [rvimm_pkg::REG_IDX_W-1:0] dest_index,
	output logic [rvimm_pkg::XLEN-1:0]    dest_value
);
	import rvimm_pkg::*;

	// Stage 1: the accepted instruction waiting for execution.
	logic        valid_s1;
	logic [31:0] instr_s1;

	// Stage 2: the finished result waiting to be taken.
	logic                 valid_s2;
	logic                 status_s2;
	logic                 wrote_s2;
	logic [REG_IDX_W-1:0] dest_index_s2;
	xword_t               dest_value_s2;

	// Architectural register file; entry 0 is never written and stays zero.
	xword_t regs_q [REG_COUNT];

	// Decoded fields of the instruction in stage 1.
	logic [6:0]           opc;
	logic [2:0]           f3;
	logic [5:0]           f6;
	logic [REG_IDX_W-1:0] rd_idx;
	logic [REG_IDX_W-1:0] rs_idx;
	logic [SHAMT_W-1:0]   shamt;
	xword_t               imm;
	xword_t               src;
	xword_t               res;
	logic                 op_ok;
	logic                 is_opimm;
	logic                 do_write;
	logic                 adv_s1;
	logic                 free_s2;

	assign opc    = instr_s1[6:0];
	assign rd_idx = instr_s1[11:7];
	assign f3     = instr_s1[14:12];
	assign rs_idx = instr_s1[19:15];
	assign shamt  = instr_s1[25:20];
	assign f6     = instr_s1[31:26];
	assign imm    = {{(XLEN-12){instr_s1[31]}}, instr_s1[31:20]};
	assign src    = regs_q[rs_idx];

	// The ALU proper: one adder, two comparators, left and right barrel shifts and logic ops.
	always_comb begin
		res   = '0;
		op_ok = 1'b1;
		unique case (f3)
			F3_ADDI:  res = src + imm;
			F3_SLLI:  res = src << shamt;
			F3_SLTI:  res = {{(XLEN-1){1'b0}}, ($signed(src) < $signed(imm))};
			F3_SLTIU: res = {{(XLEN-1){1'b0}}, (src < imm)};
			F3_XORI:  res = src ^ imm;
			F3_SRXI: begin
				if (f6 == F6_SRLI) begin
					res = src >> shamt;
				end else if (f6 == F6_SRAI) begin
					res = xword_t'($signed(src) >>> shamt);
				end else begin
					// An unknown right-shift variant executes as a silent no-op.
					op_ok = 1'b0;
				end
			end
			F3_ORI:   res = src | imm;
			F3_ANDI:  res = src & imm;
			default:  op_ok = 1'b0;
		endcase
	end

	assign is_opimm = (opc == OPC_OP_IMM);
	assign do_write = is_opimm && op_ok && (rd_idx != '0);

	// Stage 2 can load when it is empty or its transaction leaves this cycle.
	assign free_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && free_s2;
	assign in_ready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			instr_s1 <= instr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2     <= is_opimm ? STATUS_OK : STATUS_BADOPC;
			wrote_s2      <= do_write;
			dest_index_s2 <= rd_idx;
			dest_value_s2 <= do_write ? res : '0;
		end
	end

	// Write-back happens as the instruction moves to stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else if (adv_s1 && do_write) begin
			regs_q[rd_idx] <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign status     = status_s2;
	assign wrote      = wrote_s2;
	assign dest_index = dest_index_s2;
	assign dest_value = dest_value_s2;

`ifndef SYNTH
	// Register x0 must never pick up a value.
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q[0] == '0)
		else $error("register x0 was written");

	// A written result always comes with a good status.
	a_wrote_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wrote_s2) |-> (status_s2 == STATUS_OK))
		else $error("write reported together with a bad opcode status");

	// A result that wrote nothing carries a zero value.
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !wrote_s2) |-> (dest_value_s2 == '0))
		else $error("nonzero value reported without a write");

	// The register file and the reported result agree after write-back.
	a_wb_match: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && do_write) |=> (regs_q[dest_index_s2] == dest_value_s2))
		else $error("register file disagrees with the reported result");
`endif

endmodule
